>>> rtl/core/mtg_pkg.sv
// Shared types, constants and function of the Mersenne twister generator.
package mtg_pkg;

  // Geometry of the state array.
  localparam int unsigned StateWords  = 624;
  localparam int unsigned TwistOffset = 397;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_SEED   = 2'd0;
  localparam logic [1:0] FUNC_RAW    = 2'd1;
  localparam logic [1:0] FUNC_RANGED = 2'd2;

  // Twist and seeding constants.
  localparam logic [31:0] TwMatrix    = 32'h9908_b0df;
  localparam logic [31:0] TwUpper     = 32'h8000_0000;
  localparam logic [31:0] TwLower     = 32'h7fff_ffff;
  localparam logic [31:0] LcgMult     = 32'd69069;
  localparam logic [31:0] DefaultSeed = 32'd4357;
  localparam logic [31:0] HalfMask    = 32'hffff_0000;
  localparam logic [32:0] RangeDiv    = 33'h0_ffff_ffff;

  // Classified operation handed from front to back.
  typedef enum logic [1:0] {
    OP_SEED,
    OP_RAW,
    OP_RANGED,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] seed_value;
    logic [30:0] max_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] random_word;
    logic [31:0] ranged_value;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] seed;
    logic [30:0] max_value;
  } cmd_t;

  // Output tempering of one state word.
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c_5680);
    y = y ^ ((y << 15) & 32'hefc6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

>>> rtl/core/mersenne_twister_generator.sv
// Top level of the MT19937 generator with its command and result queues.
//
// Operations are queued on push/full and results leave on empty/pop, one
// result per operation. A raw draw passes through the registered read of
// the state RAM and the tempering register, and a ranged draw also through
// the product and scaling registers. Every 624th draw first twists the whole
// state in place, word by word, since each new word needs three reads
// through the one read port. Seeding writes each word from two 69069 steps;
// a draw before any seed adds a default seed and a twist. The command queue
// holds two operations, so the input side keeps accepting while the engine
// is busy or a result waits.
module mersenne_twister_generator #(
  parameter int unsigned StateWords  = mtg_pkg::StateWords,
  parameter int unsigned TwistOffset = mtg_pkg::TwistOffset
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  mtg_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output mtg_pkg::out_item_t out_item_o
);

  mtg_pkg::cmd_t      cmd_in, cmd_out;
  logic [$bits(mtg_pkg::cmd_t)-1:0]      cmd_vec;
  logic [$bits(mtg_pkg::out_item_t)-1:0] res_vec;
  logic               cmd_empty, cmd_pop;
  mtg_pkg::out_item_t res;
  logic               res_push, res_full;

  mtg_front u_front (
    .in_item_i (in_item_i),
    .cmd_o     (cmd_in)
  );

  // Command queue between classification and execution.
  mtg_fifo #(
    .Width ($bits(mtg_pkg::cmd_t)),
    .Depth (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_vec),
    .empty_o (cmd_empty)
  );

  assign cmd_out = mtg_pkg::cmd_t'(cmd_vec);

  mtg_back #(
    .StateWords  (StateWords),
    .TwistOffset (TwistOffset)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Result queue toward the consumer.
  mtg_fifo #(
    .Width ($bits(mtg_pkg::out_item_t)),
    .Depth (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_vec),
    .empty_o (empty)
  );

  assign out_item_o = mtg_pkg::out_item_t'(res_vec);

endmodule

>>> rtl/core/mtg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mtg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/mtg_fifo.sv
// Small register queue used between the pipeline sections.
module mtg_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/mtg_front.sv
// Front section: classifies each incoming transaction into a command.
module mtg_front (
  input  mtg_pkg::in_item_t in_item_i,
  output mtg_pkg::cmd_t     cmd_o
);

  // Decode the operation code; the unused code becomes a no-op.
  always_comb begin
    cmd_o.seed      = in_item_i.seed_value;
    cmd_o.max_value = in_item_i.max_value;
    unique case (in_item_i.func)
      mtg_pkg::FUNC_SEED:   cmd_o.op = mtg_pkg::OP_SEED;
      mtg_pkg::FUNC_RAW:    cmd_o.op = mtg_pkg::OP_RAW;
      mtg_pkg::FUNC_RANGED: cmd_o.op = mtg_pkg::OP_RANGED;
      default:              cmd_o.op = mtg_pkg::OP_NOP;
    endcase
  end

endmodule

>>> rtl/core/mtg_back.sv
// Back section: seeding, twisting, tempering and range scaling engine.
module mtg_back #(
  parameter int unsigned StateWords  = mtg_pkg::StateWords,
  parameter int unsigned TwistOffset = mtg_pkg::TwistOffset
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mtg_pkg::cmd_t      cmd_i,
  input  logic               cmd_empty_i,
  output logic               cmd_pop_o,
  output mtg_pkg::out_item_t res_o,
  output logic               res_push_o,
  input  logic               res_full_i
);

  localparam int unsigned AddrW = $clog2(StateWords);
  localparam int unsigned IdxW  = $clog2(StateWords + 2);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEED_A = 4'd1;
  localparam logic [3:0] S_SEED_B = 4'd2;
  localparam logic [3:0] S_TW0    = 4'd3;
  localparam logic [3:0] S_TW1    = 4'd4;
  localparam logic [3:0] S_TW2    = 4'd5;
  localparam logic [3:0] S_TW3    = 4'd6;
  localparam logic [3:0] S_READ   = 4'd7;
  localparam logic [3:0] S_TEMPER = 4'd8;
  localparam logic [3:0] S_MUL    = 4'd9;
  localparam logic [3:0] S_DIV    = 4'd10;
  localparam logic [3:0] S_RESULT = 4'd11;

  logic [3:0]       state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0] k_q, k_d;
  logic             draw_q, draw_d;
  logic             ranged_q, ranged_d;
  logic [31:0]      s_q, s_d;
  logic [31:0]      hi_q, hi_d;
  logic [31:0]      a_q, a_d, b_q, b_d;
  logic [30:0]      max_q, max_d;
  logic [31:0]      word_q, word_d;
  logic [31:0]      rng_q, rng_d;
  logic [62:0]      prod_q, prod_d;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [31:0]      wdata, rdata;
  logic [AddrW-1:0] k_next, k_far;
  logic [AddrW:0]   far_sum;
  logic [31:0]      y, lcg;
  logic [32:0]      fold;
  logic             last_k;

  mtg_ram #(
    .Width (32),
    .Depth (StateWords)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Neighbor addresses of the word being twisted.
  assign last_k  = (k_q == AddrW'(StateWords - 1));
  assign k_next  = last_k ? '0 : k_q + 1'b1;
  assign far_sum = {1'b0, k_q} + (AddrW + 1)'(TwistOffset);
  assign k_far   = (far_sum >= (AddrW + 1)'(StateWords)) ?
                   AddrW'(far_sum - (AddrW + 1)'(StateWords)) : AddrW'(far_sum);
  assign y       = (a_q & mtg_pkg::TwUpper) | (b_q & mtg_pkg::TwLower);
  assign lcg     = s_q * mtg_pkg::LcgMult + 32'd1;
  assign fold    = {2'b00, prod_q[62:32]} + {1'b0, prod_q[31:0]};

  assign res_o.random_word  = word_q;
  assign res_o.ranged_value = rng_q;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    k_d        = k_q;
    draw_d     = draw_q;
    ranged_d   = ranged_q;
    s_d        = s_q;
    hi_d       = hi_q;
    a_d        = a_q;
    b_d        = b_q;
    max_d      = max_q;
    word_d     = word_q;
    rng_d      = rng_q;
    prod_d     = prod_q;
    we         = 1'b0;
    waddr      = k_q;
    wdata      = '0;
    raddr      = k_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          max_d     = cmd_i.max_value;
          word_d    = '0;
          rng_d     = '0;
          k_d       = '0;
          draw_d    = 1'b0;
          ranged_d  = (cmd_i.op == mtg_pkg::OP_RANGED);
          unique case (cmd_i.op)
            mtg_pkg::OP_SEED: begin
              s_d     = cmd_i.seed;
              state_d = S_SEED_A;
            end
            mtg_pkg::OP_RAW, mtg_pkg::OP_RANGED: begin
              if (idx_q > IdxW'(StateWords)) begin
                // Draw before any seed: seed with the default first.
                s_d     = mtg_pkg::DefaultSeed;
                draw_d  = 1'b1;
                state_d = S_SEED_A;
              end else if (idx_q == IdxW'(StateWords)) begin
                state_d = S_TW0;
              end else begin
                state_d = S_READ;
              end
            end
            default: state_d = S_RESULT;
          endcase
        end
      end
      S_SEED_A: begin
        hi_d    = s_q & mtg_pkg::HalfMask;
        s_d     = lcg;
        state_d = S_SEED_B;
      end
      S_SEED_B: begin
        we    = 1'b1;
        wdata = hi_q | (s_q >> 16);
        s_d   = lcg;
        k_d   = k_next;
        if (last_k) begin
          idx_d   = IdxW'(StateWords);
          state_d = draw_q ? S_TW0 : S_RESULT;
        end else begin
          state_d = S_SEED_A;
        end
      end
      S_TW0: begin
        raddr   = k_q;
        state_d = S_TW1;
      end
      S_TW1: begin
        raddr   = k_next;
        a_d     = rdata;
        state_d = S_TW2;
      end
      S_TW2: begin
        raddr   = k_far;
        b_d     = rdata;
        state_d = S_TW3;
      end
      S_TW3: begin
        we    = 1'b1;
        wdata = rdata ^ (y >> 1) ^ (y[0] ? mtg_pkg::TwMatrix : 32'd0);
        k_d   = k_next;
        if (last_k) begin
          idx_d   = '0;
          state_d = S_READ;
        end else begin
          state_d = S_TW0;
        end
      end
      S_READ: begin
        raddr   = idx_q[AddrW-1:0];
        state_d = S_TEMPER;
      end
      S_TEMPER: begin
        word_d  = mtg_pkg::temper(rdata);
        idx_d   = idx_q + 1'b1;
        state_d = ranged_q ? S_MUL : S_RESULT;
      end
      S_MUL: begin
        prod_d  = 63'(max_q) * 63'(word_q);
        state_d = S_DIV;
      end
      S_DIV: begin
        // Divide by 2^32-1 (high part plus one correction step), then add one.
        rng_d   = {1'b0, prod_q[62:32]} + 32'(fold >= mtg_pkg::RangeDiv) + 32'd1;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= IdxW'(StateWords + 1);
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    draw_q   <= draw_d;
    ranged_q <= ranged_d;
    s_q      <= s_d;
    hi_q     <= hi_d;
    a_q      <= a_d;
    b_q      <= b_d;
    max_q    <= max_d;
    word_q   <= word_d;
    rng_q    <= rng_d;
    prod_q   <= prod_d;
  end

  // The state array is written only by seeding or twisting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_SEED_B || state_q == S_TW3))
    else $error("state array written outside seed or twist");

  // A command taken from the queue always starts work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q != S_IDLE))
    else $error("command popped without starting work");

  // The read index never passes the unseeded mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(StateWords + 1))
    else $error("word index out of range");

  // A finished twist leaves the index at the start of the state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TW3 && last_k) |=> (idx_q == '0 && state_q == S_READ))
    else $error("twist did not rewind the index");

endmodule

>>> dv/mersenne_twister_generator_tb.sv
// Self-checking testbench of the MT19937 generator with a built-in prediction of every result.
module mersenne_twister_generator_tb;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned NumWords = 624;
  localparam int unsigned FarOffset = 397;
  localparam int unsigned IdleLimit = 30000;
  localparam int unsigned RandomOps = 900;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  logic empty;
  logic pop;
  mtg_pkg::in_item_t in_item;
  mtg_pkg::out_item_t out_item;

  // Predicted generator state.
  logic [31:0] mt_words [NumWords];
  int unsigned mt_pos;

  // Results awaited from the block, oldest first.
  mtg_pkg::out_item_t pending_results [$];

  int unsigned mismatches;
  int unsigned idle_cycles;
  bit steady;

  mersenne_twister_generator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  // Clock with a period of 20 units.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Fills the state from the 69069 congruential sequence.
  function automatic void fill_words(input logic [31:0] seed);
    logic [31:0] s;
    logic [31:0] w;
    s = seed;
    for (int i = 0; i < NumWords; i++) begin
      w = s & 32'hffff_0000;
      s = s * 32'd69069 + 32'd1;
      w = w | (s >> 16);
      s = s * 32'd69069 + 32'd1;
      mt_words[i] = w;
    end
    mt_pos = NumWords;
  endfunction

  // Regenerates all words of the state in place.
  function automatic void regenerate_words();
    logic [31:0] y;
    for (int k = 0; k < NumWords; k++) begin
      y = (mt_words[k] & 32'h8000_0000) | (mt_words[(k + 1) % NumWords] & 32'h7fff_ffff);
      mt_words[k] = mt_words[(k + FarOffset) % NumWords] ^ (y >> 1) ^
                    (y[0] ? 32'h9908_b0df : 32'h0);
    end
    mt_pos = 0;
  endfunction

  // Returns the next tempered word, seeding with the default if never seeded.
  function automatic logic [31:0] next_tempered();
    logic [31:0] y;
    if (mt_pos >= NumWords) begin
      if (mt_pos != NumWords) fill_words(32'd4357);
      regenerate_words();
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9d2c_5680);
    y = y ^ ((y << 15) & 32'hefc6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // Works out the result of one operation and updates the predicted state.
  function automatic mtg_pkg::out_item_t generator_result(input mtg_pkg::in_item_t op);
    mtg_pkg::out_item_t res;
    logic [63:0] scaled;
    res = '0;
    case (op.func)
      mtg_pkg::FUNC_SEED: begin
        fill_words(op.seed_value);
      end
      mtg_pkg::FUNC_RAW: begin
        res.random_word = next_tempered();
      end
      mtg_pkg::FUNC_RANGED: begin
        res.random_word = next_tempered();
        scaled = ({33'd0, op.max_value} * {32'd0, res.random_word}) / 64'hffff_ffff + 64'd1;
        res.ranged_value = scaled[31:0];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Picks an idle gap: mostly none or short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one operation and records its expected result once it is accepted.
  task automatic send_op(input logic [1:0] func, input logic [31:0] seed,
                         input logic [30:0] max_value);
    int unsigned gap;
    mtg_pkg::in_item_t op;
    gap = pick_gap();
    op.func = func;
    op.seed_value = seed;
    op.max_value = max_value;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item <= op;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_results.push_back(generator_result(op));
  endtask

  // Result side: random pop stalls, checking of each transaction and the watchdog.
  int unsigned pop_hold;
  always @(posedge clk_i) begin
    int unsigned r;
    mtg_pkg::out_item_t want;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("mersenne_twister_generator_tb: done, errors");
        $finish;
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", out_item);
        end else begin
          want = pending_results.pop_front();
          if (out_item.random_word !== want.random_word ||
              out_item.ranged_value !== want.ranged_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: word exp %h got %h, ranged exp %h got %h",
                       want.random_word, out_item.random_word,
                       want.ranged_value, out_item.ranged_value);
          end
        end
      end
      r = $urandom_range(0, 99);
      if (steady) begin
        pop <= 1'b1;
      end else if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold <= pop_hold - 1;
      end else if (r < 70) begin
        pop <= 1'b1;
      end else if (r < 95) begin
        pop <= 1'b0;
        pop_hold <= $urandom_range(0, 3);
      end else begin
        pop <= 1'b0;
        pop_hold <= $urandom_range(10, 40);
      end
    end
  end

  // A draw before any seed must use the default seed; the unused code follows.
  task automatic test_unseeded_draw();
    send_op(mtg_pkg::FUNC_RANGED, 32'd0, 31'd1000);
    send_op(mtg_pkg::FUNC_RAW, 32'hffff_ffff, 31'h7fff_ffff);
    send_op(FUNC_UNUSED, 32'h1234_5678, 31'd9);
  endtask

  // Seeds at both extremes followed by raw draws, then one more seed.
  task automatic test_seed_extremes();
    send_op(mtg_pkg::FUNC_SEED, 32'd0, 31'd0);
    send_op(mtg_pkg::FUNC_RAW, 32'd0, 31'd0);
    send_op(mtg_pkg::FUNC_RAW, 32'd0, 31'd0);
    send_op(mtg_pkg::FUNC_SEED, 32'hffff_ffff, 31'h7fff_ffff);
    send_op(mtg_pkg::FUNC_RAW, 32'hffff_ffff, 31'h7fff_ffff);
    send_op(mtg_pkg::FUNC_SEED, 32'h8000_0001, 31'd3);
  endtask

  // Ranged draws at zero, one and the largest bound, plus the unused code.
  task automatic test_ranged_bounds();
    send_op(mtg_pkg::FUNC_RANGED, 32'd0, 31'd0);
    send_op(mtg_pkg::FUNC_RANGED, 32'd0, 31'd1);
    send_op(mtg_pkg::FUNC_RANGED, 32'd0, 31'h7fff_ffff);
    send_op(mtg_pkg::FUNC_RANGED, 32'hffff_ffff, 31'h4000_0000);
    send_op(FUNC_UNUSED, 32'hffff_ffff, 31'h7fff_ffff);
    send_op(mtg_pkg::FUNC_RANGED, 32'd0, 31'h5555_5555);
  endtask

  // Mostly draws with random content, occasional reseeds and unused codes.
  task automatic test_random_mix();
    int unsigned r;
    logic [30:0] bound;
    for (int n = 0; n < RandomOps; n++) begin
      steady = (n >= 300 && n < 400);
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: bound = 31'($urandom_range(0, 3));
        1: bound = 31'($urandom_range(0, 1000));
        default: bound = 31'($urandom);
      endcase
      if (r < 3) send_op(mtg_pkg::FUNC_SEED, $urandom, bound);
      else if (r < 6) send_op(FUNC_UNUSED, $urandom, bound);
      else if (r < 50) send_op(mtg_pkg::FUNC_RAW, $urandom, bound);
      else send_op(mtg_pkg::FUNC_RANGED, $urandom, bound);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_item = '0;
    mismatches = 0;
    idle_cycles = 0;
    pop_hold = 0;
    steady = 1'b0;
    mt_pos = NumWords + 1;
    foreach (mt_words[i]) mt_words[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unseeded_draw();
    test_seed_extremes();
    test_ranged_bounds();
    test_random_mix();
    push <= 1'b0;
    // Drain the outstanding results; the watchdog covers a hang.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("mersenne_twister_generator_tb: done, clean");
    end else begin
      $display("mersenne_twister_generator_tb: done, errors");
    end
    $finish;
  end

endmodule
